// ----- design/alignment_flag_statistics_top_macros.svh -----
// assertion macros shared by the flag statistics block
`ifndef ALIGNMENT_FLAG_STATISTICS_TOP_MACROS_SVH
`define ALIGNMENT_FLAG_STATISTICS_TOP_MACROS_SVH

`ifndef SYNTHESIS
// check a property while out of reset
`define AFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("afs assertion failed");
// check a property at every edge, reset included
`define AFS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("afs assertion failed");
`else
`define AFS_ASSERT(label, clk, rst_n, prop)
`define AFS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/afs_pkg.sv -----
// shared types and constants of the alignment flag statistics block
`default_nettype none

package afs_pkg;

    localparam int unsigned COUNT_WIDTH = 40;
    localparam int unsigned NUM_CAT     = 13;
    localparam int unsigned BANK_DEPTH  = 2 * NUM_CAT;
    localparam int unsigned IDX_W       = 5;
    localparam int unsigned FLAG_W      = 12;
    localparam int unsigned QUAL_W      = 8;
    localparam int unsigned REF_W       = 32;
    localparam int unsigned APB_AW      = 3;
    localparam int unsigned APB_DW      = 32;

    // item functions
    localparam logic FUNC_ACCOUNT = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    // register indexes
    localparam logic REG_HQ_THRESHOLD = 1'b0;
    localparam logic [QUAL_W-1:0] HQ_THRESHOLD_RESET = 8'd5;

    // flag bit positions
    localparam int unsigned FB_PAIRED    = 0;
    localparam int unsigned FB_PROPER    = 1;
    localparam int unsigned FB_UNMAP     = 2;
    localparam int unsigned FB_MUNMAP    = 3;
    localparam int unsigned FB_READ1     = 6;
    localparam int unsigned FB_READ2     = 7;
    localparam int unsigned FB_SECONDARY = 8;
    localparam int unsigned FB_QCFAIL    = 9;
    localparam int unsigned FB_DUP       = 10;
    localparam int unsigned FB_SUPP      = 11;

    // counter categories within one class
    localparam int unsigned CAT_TOTAL       = 0;
    localparam int unsigned CAT_SECONDARY   = 1;
    localparam int unsigned CAT_SUPP        = 2;
    localparam int unsigned CAT_DUP         = 3;
    localparam int unsigned CAT_MAPPED      = 4;
    localparam int unsigned CAT_PAIRED      = 5;
    localparam int unsigned CAT_READ1       = 6;
    localparam int unsigned CAT_READ2       = 7;
    localparam int unsigned CAT_PROPER      = 8;
    localparam int unsigned CAT_BOTH_MAPPED = 9;
    localparam int unsigned CAT_SINGLETON   = 10;
    localparam int unsigned CAT_DIFF_REF    = 11;
    localparam int unsigned CAT_DIFF_REF_HQ = 12;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // counter increments decoded from one record
    typedef struct packed {
        logic               qc_fail;
        logic [NUM_CAT-1:0] cat;
    } t_bump;

endpackage

`default_nettype wire

// ----- design/afs_if.sv -----
// stream interfaces for records in and counter values out
`default_nettype none

interface afs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [afs_pkg::FLAG_W-1:0]          flag_word;
    logic signed [afs_pkg::REF_W-1:0]    reference_id;
    logic signed [afs_pkg::REF_W-1:0]    mate_reference_id;
    logic [afs_pkg::QUAL_W-1:0]          mapping_quality;
    logic [afs_pkg::IDX_W-1:0]           counter_index;

    modport source (
        output valid, func, flag_word, reference_id, mate_reference_id,
               mapping_quality, counter_index,
        input  ready
    );
    modport sink (
        input  valid, func, flag_word, reference_id, mate_reference_id,
               mapping_quality, counter_index,
        output ready
    );
endinterface

interface afs_out_if;
    logic                  valid;
    logic                  ready;
    afs_pkg::t_count       counter_value;

    modport source (output valid, counter_value, input ready);
    modport sink (input valid, counter_value, output ready);
endinterface

`default_nettype wire

// ----- design/afs_decode.sv -----
// flag word decoder: which counters one record bumps
`default_nettype none

module afs_decode (
    input  wire logic [afs_pkg::FLAG_W-1:0]       i_flag_word,
    input  wire logic signed [afs_pkg::REF_W-1:0] i_reference_id,
    input  wire logic signed [afs_pkg::REF_W-1:0] i_mate_reference_id,
    input  wire logic [afs_pkg::QUAL_W-1:0]       i_mapping_quality,
    input  wire logic [afs_pkg::QUAL_W-1:0]       i_hq_threshold,
    output afs_pkg::t_bump                        o_bump
);

    logic secondary;
    logic supp;
    logic unmap;
    logic munmap;
    logic pair_path;
    logic both_mapped;
    logic diff_ref;

    always_comb begin
        secondary   = i_flag_word[afs_pkg::FB_SECONDARY];
        supp        = i_flag_word[afs_pkg::FB_SUPP];
        unmap       = i_flag_word[afs_pkg::FB_UNMAP];
        munmap      = i_flag_word[afs_pkg::FB_MUNMAP];
        // pair statistics only for primary, non-supplementary paired records
        pair_path   = !secondary && !supp && i_flag_word[afs_pkg::FB_PAIRED];
        both_mapped = pair_path && !unmap && !munmap;
        diff_ref    = both_mapped && (i_reference_id != i_mate_reference_id);

        o_bump.qc_fail = i_flag_word[afs_pkg::FB_QCFAIL];
        o_bump.cat     = '0;
        o_bump.cat[afs_pkg::CAT_TOTAL]       = 1'b1;
        o_bump.cat[afs_pkg::CAT_SECONDARY]   = secondary;
        o_bump.cat[afs_pkg::CAT_SUPP]        = !secondary && supp;
        o_bump.cat[afs_pkg::CAT_DUP]         = i_flag_word[afs_pkg::FB_DUP];
        o_bump.cat[afs_pkg::CAT_MAPPED]      = !unmap;
        o_bump.cat[afs_pkg::CAT_PAIRED]      = pair_path;
        o_bump.cat[afs_pkg::CAT_READ1]       = pair_path && i_flag_word[afs_pkg::FB_READ1];
        o_bump.cat[afs_pkg::CAT_READ2]       = pair_path && i_flag_word[afs_pkg::FB_READ2];
        o_bump.cat[afs_pkg::CAT_PROPER]      = pair_path && i_flag_word[afs_pkg::FB_PROPER]
                                               && !unmap;
        o_bump.cat[afs_pkg::CAT_BOTH_MAPPED] = both_mapped;
        o_bump.cat[afs_pkg::CAT_SINGLETON]   = pair_path && munmap && !unmap;
        o_bump.cat[afs_pkg::CAT_DIFF_REF]    = diff_ref;
        o_bump.cat[afs_pkg::CAT_DIFF_REF_HQ] = diff_ref
                                               && (i_mapping_quality >= i_hq_threshold);
    end

endmodule

`default_nettype wire

// ----- design/afs_bank.sv -----
// bank of saturating statistics counters with one read port
`default_nettype none
`include "alignment_flag_statistics_top_macros.svh"

module afs_bank (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_bump_en,
    input  wire afs_pkg::t_bump            i_bump,
    input  wire logic [afs_pkg::IDX_W-1:0] i_rd_index,
    output afs_pkg::t_count                o_rd_value
);

    localparam afs_pkg::t_count COUNT_MAX = '1;

    // bank positions watched by the assertions
    localparam int unsigned IX_TOTAL       = afs_pkg::CAT_TOTAL;
    localparam int unsigned IX_MAPPED      = afs_pkg::CAT_MAPPED;
    localparam int unsigned IX_QC_TOTAL    = afs_pkg::NUM_CAT + afs_pkg::CAT_TOTAL;
    localparam int unsigned IX_QC_PAIRED   = afs_pkg::NUM_CAT + afs_pkg::CAT_PAIRED;
    localparam int unsigned IX_DIFF_REF    = afs_pkg::CAT_DIFF_REF;
    localparam int unsigned IX_DIFF_REF_HQ = afs_pkg::CAT_DIFF_REF_HQ;

    afs_pkg::t_count r_cnt [afs_pkg::BANK_DEPTH];
    logic [afs_pkg::BANK_DEPTH-1:0] hit;

    // class 0 occupies the lower half of the bank, qc-failed the upper
    always_comb begin
        for (int c = 0; c < afs_pkg::NUM_CAT; c++) begin
            hit[c]                    = i_bump_en && !i_bump.qc_fail && i_bump.cat[c];
            hit[afs_pkg::NUM_CAT + c] = i_bump_en && i_bump.qc_fail && i_bump.cat[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < afs_pkg::BANK_DEPTH; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            for (int i = 0; i < afs_pkg::BANK_DEPTH; i++) begin
                if (hit[i] && (r_cnt[i] != COUNT_MAX)) begin
                    r_cnt[i] <= r_cnt[i] + afs_pkg::t_count'(1);
                end
            end
        end
    end

    always_comb begin
        if (i_rd_index < afs_pkg::IDX_W'(afs_pkg::BANK_DEPTH)) begin
            o_rd_value = r_cnt[i_rd_index];
        end else begin
            o_rd_value = '0;
        end
    end

    `AFS_ASSERT(a_total_covers_mapped, i_clk, i_rst_n, r_cnt[IX_TOTAL] >= r_cnt[IX_MAPPED])
    `AFS_ASSERT(a_qc_total_covers_paired, i_clk, i_rst_n, r_cnt[IX_QC_TOTAL] >= r_cnt[IX_QC_PAIRED])
    `AFS_ASSERT(a_diff_ref_covers_hq, i_clk, i_rst_n, r_cnt[IX_DIFF_REF] >= r_cnt[IX_DIFF_REF_HQ])

endmodule

`default_nettype wire

// ----- design/alignment_flag_statistics_top.sv -----
// top level of the alignment flag statistics block
`default_nettype none
`include "alignment_flag_statistics_top_macros.svh"

// Alignment flag statistics. Each input transfer either accounts one alignment
// record (func 0) into 26 saturating 40-bit counters, 13 per QC class, or reads
// one counter (func 1) selected by counter_index = class * 13 + category;
// indexes 26 to 31 read as zero. A record transfer yields no output transfer,
// a read yields exactly one. The block takes one item per clock unless stalled:
// each item waits in the input register, where the flag decode and all counter
// increments happen in parallel, and a read result then waits in the output
// register. The input stalls only while a read waits behind a result the sink
// has not taken.
// The quality threshold for the different-reference category lives at APB byte
// address 0 (reset value 5) and should be written only while the block is idle.
module alignment_flag_statistics_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    afs_in_if.sink                            i_in,
    afs_out_if.source                         o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [afs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [afs_pkg::APB_DW-1:0]   pwdata,
    output logic [afs_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    // configuration register
    logic [afs_pkg::QUAL_W-1:0] r_hq_threshold;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == afs_pkg::REG_HQ_THRESHOLD);
    assign prdata  = reg_sel ? afs_pkg::APB_DW'(r_hq_threshold) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hq_threshold <= afs_pkg::HQ_THRESHOLD_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_hq_threshold <= pwdata[afs_pkg::QUAL_W-1:0];
        end
    end

    // input register
    logic                              r_s1_valid;
    logic                              r_s1_func;
    logic [afs_pkg::FLAG_W-1:0]        r_s1_flag;
    logic signed [afs_pkg::REF_W-1:0]  r_s1_tid;
    logic signed [afs_pkg::REF_W-1:0]  r_s1_mtid;
    logic [afs_pkg::QUAL_W-1:0]        r_s1_qual;
    logic [afs_pkg::IDX_W-1:0]         r_s1_index;

    // output register
    logic                              r_out_valid;
    afs_pkg::t_count                   r_out_value;

    logic            s1_go;
    logic            rd_go;
    logic            in_xfer;
    afs_pkg::t_bump  bump;
    afs_pkg::t_count rd_value;

    // a read needs the output slot, an account never waits
    assign s1_go = r_s1_valid
                   && ((r_s1_func == afs_pkg::FUNC_ACCOUNT) || !r_out_valid || o_out.ready);
    assign rd_go      = s1_go && (r_s1_func == afs_pkg::FUNC_READ);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_func  <= i_in.func;
            r_s1_flag  <= i_in.flag_word;
            r_s1_tid   <= i_in.reference_id;
            r_s1_mtid  <= i_in.mate_reference_id;
            r_s1_qual  <= i_in.mapping_quality;
            r_s1_index <= i_in.counter_index;
        end
    end

    afs_decode u_decode (
        .i_flag_word         (r_s1_flag),
        .i_reference_id      (r_s1_tid),
        .i_mate_reference_id (r_s1_mtid),
        .i_mapping_quality   (r_s1_qual),
        .i_hq_threshold      (r_hq_threshold),
        .o_bump              (bump)
    );

    afs_bank u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bump_en  (s1_go && (r_s1_func == afs_pkg::FUNC_ACCOUNT)),
        .i_bump     (bump),
        .i_rd_index (r_s1_index),
        .o_rd_value (rd_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rd_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_out_value <= rd_value;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.counter_value = r_out_value;

    `AFS_ASSERT(a_read_fills_output, i_clk, i_rst_n, rd_go |=> r_out_valid)
    `AFS_ASSERT(a_no_spurious_result, i_clk, i_rst_n, (!r_out_valid && !rd_go) |=> !r_out_valid)
    `AFS_ASSERT_ALWAYS(a_reset_empties_pipe, i_clk, !i_rst_n |=> (!r_out_valid && !r_s1_valid))

endmodule

`default_nettype wire
